// ===== sv/tel_pkg.sv =====
// Shared constants and codes for the throttle expo / ramp limiter.
// No dependencies; compile first.
package tel_pkg;

  localparam int PULSE_BITS_DEF = 12;
  localparam int TIME_BITS_DEF  = 32;
  localparam int MODE_BITS      = 2;
  localparam int CFG_IDX_BITS   = 3;

  // Q0.16 expo weight and cube limit
  localparam int EXPO_BITS      = 16;
  localparam int CUBE_CAP_BITS  = 40;

  localparam int DEADBAND_US    = 50;

  // thermal cap = center + floor(CAP_NUM * span / CAP_DEN)
  localparam int CAP_NUM        = 7;
  localparam int CAP_DEN        = 10;

  // register reset values
  localparam int CENTER_RST     = 1500;
  localparam int MIN_RST        = 1000;
  localparam int MAX_RST        = 2000;
  localparam int EXPO_RST       = 19661;
  localparam int STEP_RST       = 10;
  localparam int HOT_TH_RST     = 1800;
  localparam int HOT_TIME_RST   = 5000;

  typedef enum logic [MODE_BITS-1:0] {
    MODE_CMD  = 2'd0,
    MODE_TICK = 2'd1,
    MODE_FAIL = 2'd2
  } mode_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_CENTER   = 3'd0,
    REG_MIN      = 3'd1,
    REG_MAX      = 3'd2,
    REG_EXPO     = 3'd3,
    REG_STEP     = 3'd4,
    REG_HOT_TH   = 3'd5,
    REG_HOT_TIME = 3'd6
  } cfg_reg_e;

endpackage

// ===== sv/tel_if.sv =====
// Valid/ready channel interfaces for command input and pulse output words.
// Depends on tel_pkg.
interface tel_in_if import tel_pkg::*; #(
  parameter int PULSE_BITS = PULSE_BITS_DEF,
  parameter int TIME_BITS  = TIME_BITS_DEF
) ();
  logic                  valid;
  logic                  ready;
  logic [MODE_BITS-1:0]  mode;
  logic [PULSE_BITS-1:0] pulse_in;
  logic [TIME_BITS-1:0]  now_ms;

  modport source (output valid, output mode, output pulse_in, output now_ms, input ready);
  modport sink   (input valid, input mode, input pulse_in, input now_ms, output ready);
endinterface

interface tel_out_if import tel_pkg::*; #(
  parameter int PULSE_BITS = PULSE_BITS_DEF
) ();
  logic                  valid;
  logic                  ready;
  logic [PULSE_BITS-1:0] pulse_out;

  modport source (output valid, output pulse_out, input ready);
  modport sink   (input valid, input pulse_out, output ready);
endinterface

// ===== sv/throttle_expo_ramp_limiter_top.sv =====
// Throttle shaper top: command shaping (deadband, reversal guard, cubic expo),
// tick processing (thermal cap, snap to center, ramp) and failsafe.
// Depends on tel_pkg, tel_if (tel_in_if, tel_out_if), tel_div, tel_mul.
//
//   channel   dir  handshake      word
//   in_i      in   valid/ready    mode, pulse_in, now_ms
//   out_o     out  valid/ready    pulse_out (tick and failsafe words only)
//   cfg       in   cfg_we_i only  cfg_idx_i, cfg_data_i
//
// A command returns to idle straight from its command state on a snap to center,
// skips the divider and multiplies on a zero span, and else runs a 2*PULSE_BITS + 16
// step divider and two 17-step multiplies. Tick and failsafe words run their own states.
// Reset clears drive and goal to the reset center, direction to forward, the
// hot timer to idle and all configuration registers to their reset values.
// Stalls: one output word is held in a register; a new input word is taken
// while it waits, and a later result holds in its last step until it drains.
module throttle_expo_ramp_limiter_top import tel_pkg::*; #(
  parameter int PULSE_BITS = PULSE_BITS_DEF,
  parameter int TIME_BITS  = TIME_BITS_DEF,
  localparam int CFG_W0    = (TIME_BITS > PULSE_BITS) ? TIME_BITS : PULSE_BITS,
  localparam int CFG_W     = (CFG_W0 > EXPO_BITS) ? CFG_W0 : EXPO_BITS
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  tel_in_if.sink                  in_i,
  tel_out_if.source               out_o,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]        cfg_data_i
);

  localparam int P       = PULSE_BITS;
  localparam int T       = TIME_BITS;
  // expo datapath widths
  localparam int NUM_W   = 2 * P + EXPO_BITS;      // a^2 << 16
  localparam int DEN_W   = 2 * P;                  // s^2
  localparam int CUBE_W  = CUBE_CAP_BITS + 1;
  localparam int MA_W    = (NUM_W > CUBE_W) ? NUM_W : CUBE_W;
  localparam int MB_W    = EXPO_BITS + 1;
  localparam int MP_W    = MA_W + MB_W;
  localparam int SUM_W   = CUBE_W + MB_W;          // a*(1-e) + cube*e
  localparam int MAG_W   = SUM_W - EXPO_BITS;
  localparam int R_W     = MAG_W + 2;
  localparam int LIN_W   = P + MB_W;
  // thermal cap: divide by ten through a reciprocal
  localparam int UW      = P + 3;
  localparam int RK      = UW + 4;
  localparam int QQ_W    = P + 1;
  localparam int RP_W    = RK + QQ_W;
  localparam int RECIP   = ((2 ** RK) + CAP_DEN - 1) / CAP_DEN;

  localparam logic [MA_W:0]   CUBE_CAP_V =
    {{(MA_W - CUBE_CAP_BITS){1'b0}}, 1'b1, {CUBE_CAP_BITS{1'b0}}};
  localparam logic [MB_W-1:0] ONE_Q16 = {1'b1, {EXPO_BITS{1'b0}}};

  typedef enum logic [3:0] {
    ST_IDLE, ST_CMD, ST_PREP, ST_SQ, ST_DEN, ST_DIV, ST_MUL1, ST_CUBE,
    ST_MUL2, ST_SIGN, ST_CLAMP, ST_TICK1, ST_TICK2, ST_TICK3, ST_TICK4, ST_FAIL
  } state_e;

  state_e state_q;

  // configuration
  logic [P-1:0]         center_q, min_q, max_q, step_q, hot_th_q;
  logic [EXPO_BITS-1:0] expo_q;
  logic [T-1:0]         hot_time_q;

  // architectural state
  logic [P-1:0] drive_q, goal_q;
  logic         fwd_q, timing_q;
  logic [T-1:0] since_q;

  // output word
  logic         out_vld_q;
  logic [P-1:0] out_pulse_q;

  // datapath payload
  logic [P-1:0]     raw_q, x_q, a_q, sabs_q;
  logic [T-1:0]     now_q;
  logic             negd_q;
  logic [2*P-1:0]   sq_q;
  logic [LIN_W-1:0] lin_q;
  logic [CUBE_W-1:0] cube_q;
  logic [MAG_W-1:0] mag_q;
  logic signed [R_W-1:0] r_q;
  logic             cap_en_q, capneg_q;
  logic [UW-1:0]    u_q;
  logic [QQ_W-1:0]  qq_q;

  logic in_acc, out_free, out_load;
  assign in_i.ready    = (state_q == ST_IDLE);
  assign in_acc        = in_i.valid && in_i.ready;
  assign out_free      = !out_vld_q || out_o.ready;
  // a tick or failsafe word lands in the output register this cycle
  assign out_load      = ((state_q == ST_TICK4) || (state_q == ST_FAIL)) && out_free;
  assign out_o.valid   = out_vld_q;
  assign out_o.pulse_out = out_pulse_q;

  // ---------------------------------------------------------------- serial units
  logic             div_start, div_done;
  logic [NUM_W-1:0] div_quo;
  logic [DEN_W-1:0] den_d;
  logic             mul_start, mul_done;
  logic [MA_W-1:0]  mul_a;
  logic [MB_W-1:0]  mul_b;
  logic [MP_W-1:0]  mul_prod;

  assign den_d     = DEN_W'(sabs_q) * DEN_W'(sabs_q);
  assign div_start = (state_q == ST_DEN);
  assign mul_start = ((state_q == ST_DIV) && div_done) || (state_q == ST_CUBE);
  assign mul_a     = (state_q == ST_CUBE) ? MA_W'(cube_q) : MA_W'(div_quo);
  assign mul_b     = (state_q == ST_CUBE) ? MB_W'(expo_q) : MB_W'(a_q);

  tel_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   ({sq_q, {EXPO_BITS{1'b0}}}),
    .den_i   (den_d),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  tel_mul #(.A_W(MA_W), .B_W(MB_W)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  // ---------------------------------------------------------------- command logic
  logic [P-1:0] off_abs, x_lo, x_d;
  logic         in_dead, raw_fwd, rev_block;

  always_comb begin
    off_abs   = (raw_q >= center_q) ? (raw_q - center_q) : (center_q - raw_q);
    in_dead   = (off_abs < P'(DEADBAND_US));
    raw_fwd   = (raw_q > center_q);
    rev_block = (raw_fwd != fwd_q) && (drive_q != center_q);
    x_lo      = (raw_q < min_q) ? min_q : raw_q;
    x_d       = (x_lo > max_q) ? max_q : x_lo;
  end

  // expo steps
  logic [P-1:0]      a_d, sabs_d;
  logic              s_zero;
  logic [MB_W-1:0]   one_minus_e;
  logic [LIN_W-1:0]  lin_d;
  logic [MA_W:0]     cube_hi;
  logic [CUBE_W-1:0] cube_d;
  logic [SUM_W-1:0]  sum_d;
  logic [MAG_W-1:0]  mag_d;
  logic signed [R_W-1:0] c_ext, mag_ext, min_ext, max_ext, r_d, r_lo, r_cl;

  always_comb begin
    a_d         = (x_q >= center_q) ? (x_q - center_q) : (center_q - x_q);
    sabs_d      = (max_q >= center_q) ? (max_q - center_q) : (center_q - max_q);
    s_zero      = (max_q == center_q);
    one_minus_e = ONE_Q16 - {1'b0, expo_q};
    lin_d       = LIN_W'(a_q) * LIN_W'(one_minus_e);
    cube_hi     = mul_prod[MP_W-1:EXPO_BITS];
    cube_d      = (cube_hi > CUBE_CAP_V) ? CUBE_CAP_V[CUBE_W-1:0] : cube_hi[CUBE_W-1:0];
    sum_d       = mul_prod[SUM_W-1:0] + SUM_W'(lin_q);
    mag_d       = sum_d[SUM_W-1:EXPO_BITS];
    c_ext       = $signed({{(R_W-P){1'b0}}, center_q});
    mag_ext     = $signed({2'b00, mag_q});
    min_ext     = $signed({{(R_W-P){1'b0}}, min_q});
    max_ext     = $signed({{(R_W-P){1'b0}}, max_q});
    r_d         = negd_q ? (c_ext - mag_ext) : (c_ext + mag_ext);
    // raise to min first, then lower to max: max wins on a crossed band
    r_lo        = (r_q < min_ext) ? min_ext : r_q;
    r_cl        = (r_lo > max_ext) ? max_ext : r_lo;
  end

  // ---------------------------------------------------------------- tick logic
  logic                  hot, late;
  logic [T-1:0]          elapsed;
  logic                  capneg_d;
  logic [P-1:0]          span_abs;
  logic [UW-1:0]         m7, u_d;
  logic [RP_W-1:0]       rp;
  logic signed [P+1:0]   cap_s;
  logic [P-1:0]          cap_u, goal_cap_d;
  logic                  rev, crossing;
  logic [P-1:0]          ramp_d;

  always_comb begin
    hot      = (drive_q > hot_th_q);
    elapsed  = now_q - since_q;          // wraps modulo 2^TIME_BITS
    late     = (elapsed > hot_time_q);
    capneg_d = (max_q < center_q);
    span_abs = capneg_d ? (center_q - max_q) : (max_q - center_q);
    m7       = {span_abs, 3'b000} - UW'(span_abs);
    // floor of a negative quotient: round the magnitude up
    u_d      = capneg_d ? (m7 + UW'(CAP_DEN - 1)) : m7;

    rp       = RP_W'(u_q) * RP_W'(RECIP);

    cap_s    = capneg_q ? ($signed({2'b00, center_q}) - $signed({1'b0, qq_q}))
                        : ($signed({2'b00, center_q}) + $signed({1'b0, qq_q}));
    cap_u    = cap_s[P+1] ? '0 : cap_s[P-1:0];
    goal_cap_d = (cap_en_q && (goal_q > cap_u)) ? cap_u : goal_q;

    rev      = (fwd_q && (goal_q < drive_q)) || (!fwd_q && (goal_q > drive_q));
    crossing = ((goal_q > center_q) && (drive_q < center_q)) ||
               ((goal_q < center_q) && (drive_q > center_q));
    if (rev || crossing) begin
      ramp_d = center_q;
    end else if (goal_q > drive_q) begin
      ramp_d = ((goal_q - drive_q) > step_q) ? (drive_q + step_q) : goal_q;
    end else if (goal_q < drive_q) begin
      ramp_d = ((drive_q - goal_q) > step_q) ? (drive_q - step_q) : goal_q;
    end else begin
      ramp_d = drive_q;
    end
  end

  // ---------------------------------------------------------------- control and state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      center_q    <= P'(CENTER_RST);
      min_q       <= P'(MIN_RST);
      max_q       <= P'(MAX_RST);
      expo_q      <= EXPO_BITS'(EXPO_RST);
      step_q      <= P'(STEP_RST);
      hot_th_q    <= P'(HOT_TH_RST);
      hot_time_q  <= T'(HOT_TIME_RST);
      drive_q     <= P'(CENTER_RST);
      goal_q      <= P'(CENTER_RST);
      fwd_q       <= 1'b1;
      since_q     <= '0;
      timing_q    <= 1'b0;
      out_vld_q   <= 1'b0;
      out_pulse_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_CENTER:   center_q   <= cfg_data_i[P-1:0];
          REG_MIN:      min_q      <= cfg_data_i[P-1:0];
          REG_MAX:      max_q      <= cfg_data_i[P-1:0];
          REG_EXPO:     expo_q     <= cfg_data_i[EXPO_BITS-1:0];
          REG_STEP:     step_q     <= cfg_data_i[P-1:0];
          REG_HOT_TH:   hot_th_q   <= cfg_data_i[P-1:0];
          REG_HOT_TIME: hot_time_q <= cfg_data_i[T-1:0];
          default: ;
        endcase
      end

      if (out_vld_q && out_o.ready && !out_load) begin
        out_vld_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            case (mode_e'(in_i.mode))
              MODE_CMD:  state_q <= ST_CMD;
              MODE_TICK: state_q <= ST_TICK1;
              MODE_FAIL: state_q <= ST_FAIL;
              default:   state_q <= ST_IDLE;   // reserved code, dropped
            endcase
          end
        end
        ST_CMD: begin
          if (in_dead || rev_block) begin
            goal_q  <= center_q;
            state_q <= ST_IDLE;
          end else begin
            if (drive_q == center_q) begin
              fwd_q <= raw_fwd;
            end
            state_q <= ST_PREP;
          end
        end
        ST_PREP:  state_q <= s_zero ? ST_SIGN : ST_SQ;
        ST_SQ:    state_q <= ST_DEN;
        ST_DEN:   state_q <= ST_DIV;
        ST_DIV:   if (div_done) state_q <= ST_MUL1;
        ST_MUL1:  if (mul_done) state_q <= ST_CUBE;
        ST_CUBE:  state_q <= ST_MUL2;
        ST_MUL2:  if (mul_done) state_q <= ST_SIGN;
        ST_SIGN:  state_q <= ST_CLAMP;
        ST_CLAMP: begin
          goal_q  <= r_cl[P-1:0];
          state_q <= ST_IDLE;
        end
        ST_TICK1: begin
          if (hot) begin
            if (!timing_q) begin
              since_q  <= now_q;
              timing_q <= 1'b1;
            end
          end else begin
            timing_q <= 1'b0;
          end
          state_q <= ST_TICK2;
        end
        ST_TICK2: state_q <= ST_TICK3;
        ST_TICK3: begin
          goal_q  <= goal_cap_d;
          state_q <= ST_TICK4;
        end
        ST_TICK4: begin
          if (out_free) begin
            drive_q     <= ramp_d;
            out_pulse_q <= ramp_d;
            out_vld_q   <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        ST_FAIL: begin
          if (out_free) begin
            drive_q     <= center_q;
            goal_q      <= center_q;
            fwd_q       <= 1'b1;
            out_pulse_q <= center_q;
            out_vld_q   <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------- datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          raw_q <= in_i.pulse_in;
          now_q <= in_i.now_ms;
        end
      end
      ST_CMD:  x_q <= x_d;
      ST_PREP: begin
        a_q    <= a_d;
        negd_q <= (x_q < center_q);
        sabs_q <= sabs_d;
        mag_q  <= '0;         // zero span: curve adds nothing
      end
      ST_SQ:   sq_q  <= (2*P)'(a_q) * (2*P)'(a_q);
      ST_DIV:  lin_q <= lin_d;
      ST_MUL1: if (mul_done) cube_q <= cube_d;
      ST_MUL2: if (mul_done) mag_q <= mag_d;
      ST_SIGN: r_q <= r_d;
      ST_TICK1: begin
        cap_en_q <= hot && timing_q && late;
        capneg_q <= capneg_d;
        u_q      <= u_d;
      end
      ST_TICK2: qq_q <= rp[RP_W-1:RK];
      default: ;
    endcase
  end

endmodule

// ===== sv/tel_div.sv =====
// Restoring divider, one quotient bit per cycle, MSB first.
// Depends on tel_pkg (import only).
module tel_div import tel_pkg::*; #(
  parameter int NUM_W = 2 * PULSE_BITS_DEF + EXPO_BITS,
  parameter int DEN_W = 2 * PULSE_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quo_o
);

  localparam int CW = $clog2(NUM_W + 1);

  logic [CW-1:0]    cnt_q;
  logic             done_q;
  logic [NUM_W-1:0] sh_q;   // dividend shifts out, quotient shifts in
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W:0]   trial, diff;
  logic             qbit;

  always_comb begin
    trial = {rem_q, sh_q[NUM_W-1]};
    diff  = trial - {1'b0, den_q};
    qbit  = (trial >= {1'b0, den_q});
    rem_d = qbit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= CW'(NUM_W);
      done_q <= 1'b0;
    end else if (cnt_q != '0) begin
      cnt_q  <= cnt_q - 1'b1;
      done_q <= (cnt_q == CW'(1));
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sh_q  <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (cnt_q != '0) begin
      sh_q  <= {sh_q[NUM_W-2:0], qbit};
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quo_o  = sh_q;

endmodule

// ===== sv/tel_mul.sv =====
// Shift-add multiplier, one multiplier bit per cycle, LSB first.
// Depends on tel_pkg (import only).
module tel_mul import tel_pkg::*; #(
  parameter int A_W = CUBE_CAP_BITS + 1,
  parameter int B_W = EXPO_BITS + 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [A_W-1:0]     a_i,
  input  logic [B_W-1:0]     b_i,
  output logic               done_o,
  output logic [A_W+B_W-1:0] prod_o
);

  localparam int CW = $clog2(B_W + 1);

  logic [CW-1:0]      cnt_q;
  logic               done_q;
  logic [A_W-1:0]     a_q;
  logic [A_W+B_W-1:0] prod_q;   // upper: partial sum, lower: remaining multiplier bits
  logic [A_W:0]       sum;

  assign sum = {1'b0, prod_q[A_W+B_W-1:B_W]} + (prod_q[0] ? {1'b0, a_q} : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= CW'(B_W);
      done_q <= 1'b0;
    end else if (cnt_q != '0) begin
      cnt_q  <= cnt_q - 1'b1;
      done_q <= (cnt_q == CW'(1));
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q    <= a_i;
      prod_q <= {{A_W{1'b0}}, b_i};
    end else if (cnt_q != '0) begin
      prod_q <= {sum, prod_q[B_W-1:1]};
    end
  end

  assign done_o = done_q;
  assign prod_o = prod_q;

endmodule
